// File: hdl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define FFHA_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator implication violated");

// Implication whose consequent is checked in the cycle after the antecedent.
`define FFHA_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator sequence violated");

// Invariant checked on every rising edge outside reset.
`define FFHA_ASSERT_ALWAYS(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("allocator invariant violated");

`endif

// File: hdl/ffha_pkg.sv
// Types, constants and sequencer states of the first-fit heap allocator.
package ffha_pkg;

	localparam int ADDR_W             = 48;
	localparam int SIZE_W             = 24;
	localparam int BYTES_W            = 25;
	localparam int STATUS_W           = 2;
	localparam int GRAIN              = 16;
	localparam int ROUND_ADD          = 15;
	localparam int DEF_MAX_SEGMENTS   = 64;
	localparam int DEF_HEADER_BYTES   = 32;
	localparam int DEF_HEAP_MAX_BYTES = 16777216;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic REG_HEAP_BASE  = 1'b0;
	localparam logic REG_HEAP_BYTES = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_OOM  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NULL = 2'd3;

	typedef struct packed {
		logic              command;
		logic [SIZE_W-1:0] req_size;
		logic [ADDR_W-1:0] ptr;
	} cmd_beat_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   addr;
	} res_beat_t;

	typedef struct packed {
		logic              free;
		logic [SIZE_W-1:0] size;
		logic [SIZE_W-1:0] offset;
	} seg_t;

	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_INS_RD,
		S_INS_WR,
		S_SPLIT_WR,
		S_ALLOC_WR,
		S_NEXT_RD,
		S_NEXT_CHK,
		S_PREV_RD,
		S_PREV_CHK,
		S_FREE_WR,
		S_RM_RD,
		S_RM_WR,
		S_DONE
	} state_t;

endpackage

// File: hdl/ffha_seg_mem.sv
// Segment table memory: one write port, one registered read port.
module ffha_seg_mem
	import ffha_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_SEGMENTS,
	parameter int IW    = $clog2(DEF_MAX_SEGMENTS)
) (
	input  logic          clk,
	input  mem_ctl_t      ctl,
	input  logic [IW-1:0] waddr,
	input  seg_t          wdata,
	input  logic [IW-1:0] raddr,
	output seg_t          rdata
);

	seg_t mem_q [DEPTH];
	seg_t rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator with segment coalescing.
//
//   channel | signals                        | direction | beat
//   cmd     | cmd_valid cmd_stall cmd_beat   | in        | command, req_size, ptr
//   res     | res_valid res_stall res_beat   | out       | status, addr
//   cfg     | cfg_valid cfg_ready cfg_index  | in        | cfg_data (heap_base, heap_bytes)
//
// An allocate scans the segments; when the fitting one is split, it shifts later entries up
// and writes the new free tail before the entry. A free scans for the pointer, checks the
// neighbors, shifts entries down on each merge, and writes the freed entry unless it merged
// into the previous one. A miss ends at the last segment; a null free skips the scan. After
// reset and after each heap_bytes write, the table is rebuilt. A stalled result holds in the
// output register while the next command is processed.
module first_fit_heap_allocator_top
	import ffha_pkg::*;
#(
	parameter int MAX_SEGMENTS   = DEF_MAX_SEGMENTS,
	parameter int HEADER_BYTES   = DEF_HEADER_BYTES,
	parameter int HEAP_MAX_BYTES = DEF_HEAP_MAX_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cmd_beat_t         cmd_beat,
	output logic              res_valid,
	input  logic              res_stall,
	output res_beat_t         res_beat,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [ADDR_W-1:0] cfg_data
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	state_t              state_q, state_d, ret_q;
	logic [IW-1:0]       idx_q, k_q;
	logic [CW-1:0]       count_q;
	logic [BYTES_W-1:0]  need_q, need_in;
	logic [ADDR_W-1:0]   ptr_q, base_q, seg_addr;
	logic                cmd_q;
	logic [BYTES_W-1:0]  bytes_q, bytes_in;
	seg_t                cur_q, new_q, rdata, wdata;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   addr_q;
	res_beat_t           res_q;
	logic                res_valid_q;
	mem_ctl_t            mem_ctl;
	logic [IW-1:0]       waddr, raddr;
	logic                cmd_fire, cfg_fire, res_load, is_last, fit, split_ok, hit;

	assign cmd_fire = cmd_valid && !cmd_stall;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign cmd_stall = (state_q != S_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign res_load = (state_q == S_DONE) && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res_beat = res_q;

	assign need_in = (BYTES_W'(cmd_beat.req_size) + BYTES_W'(ROUND_ADD))
		& ~BYTES_W'(GRAIN - 1);

	always_comb begin
		bytes_in = cfg_data[BYTES_W-1:0];
		if (bytes_in < BYTES_W'(HEADER_BYTES + GRAIN)) begin
			bytes_in = BYTES_W'(HEADER_BYTES + GRAIN);
		end
		if (bytes_in > BYTES_W'(HEAP_MAX_BYTES)) begin
			bytes_in = BYTES_W'(HEAP_MAX_BYTES);
		end
	end

	assign seg_addr = base_q + ADDR_W'(rdata.offset) + ADDR_W'(HEADER_BYTES);
	assign is_last = (CW'(idx_q) + CW'(1)) == count_q;
	assign fit = rdata.free && ({1'b0, rdata.size} >= need_q);
	assign split_ok = (count_q < CW'(MAX_SEGMENTS)) &&
		({2'b0, rdata.size} >= ({1'b0, need_q} + (BYTES_W+1)'(HEADER_BYTES + GRAIN)));
	assign hit = (seg_addr == ptr_q);

	ffha_seg_mem #(
		.DEPTH (MAX_SEGMENTS),
		.IW    (IW)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: state_d = S_IDLE;
			S_IDLE: begin
				if (cfg_fire && cfg_index == REG_HEAP_BYTES) begin
					state_d = S_INIT;
				end else if (cmd_fire) begin
					if (cmd_beat.command == CMD_FREE && cmd_beat.ptr == '0) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN_RD;
					end
				end
			end
			S_SCAN_RD: state_d = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (cmd_q == CMD_ALLOC) begin
					if (fit) begin
						state_d = split_ok ? S_INS_RD : S_ALLOC_WR;
					end else begin
						state_d = is_last ? S_DONE : S_SCAN_RD;
					end
				end else begin
					if (hit) begin
						state_d = rdata.free ? S_DONE : S_NEXT_RD;
					end else begin
						state_d = is_last ? S_DONE : S_SCAN_RD;
					end
				end
			end
			S_INS_RD: state_d = (k_q == idx_q + IW'(1)) ? S_SPLIT_WR : S_INS_WR;
			S_INS_WR: state_d = S_INS_RD;
			S_SPLIT_WR: state_d = S_ALLOC_WR;
			S_ALLOC_WR: state_d = S_DONE;
			S_NEXT_RD: state_d = (CW'(idx_q) + CW'(1) < count_q) ? S_NEXT_CHK : S_PREV_RD;
			S_NEXT_CHK: state_d = rdata.free ? S_RM_RD : S_PREV_RD;
			S_PREV_RD: state_d = (idx_q != '0) ? S_PREV_CHK : S_FREE_WR;
			S_PREV_CHK: state_d = rdata.free ? S_RM_RD : S_FREE_WR;
			S_FREE_WR: state_d = S_DONE;
			S_RM_RD: state_d = (CW'(k_q) + CW'(1) < count_q) ? S_RM_WR : ret_q;
			S_RM_WR: state_d = S_RM_RD;
			S_DONE: state_d = res_load ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_ctl = '0;
		waddr = idx_q;
		raddr = idx_q;
		wdata = cur_q;
		case (state_q)
			S_INIT: begin
				mem_ctl.we = 1'b1;
				waddr = '0;
				wdata.offset = '0;
				wdata.size = SIZE_W'(bytes_q - BYTES_W'(HEADER_BYTES));
				wdata.free = 1'b1;
			end
			S_SCAN_RD: mem_ctl.re = 1'b1;
			S_INS_RD: begin
				mem_ctl.re = (k_q != idx_q + IW'(1));
				raddr = k_q - IW'(1);
			end
			S_INS_WR: begin
				mem_ctl.we = 1'b1;
				waddr = k_q;
				wdata = rdata;
			end
			S_SPLIT_WR: begin
				mem_ctl.we = 1'b1;
				waddr = idx_q + IW'(1);
				wdata = new_q;
			end
			S_ALLOC_WR: mem_ctl.we = 1'b1;
			S_NEXT_RD: begin
				mem_ctl.re = 1'b1;
				raddr = idx_q + IW'(1);
			end
			S_PREV_RD: begin
				mem_ctl.re = 1'b1;
				raddr = idx_q - IW'(1);
			end
			S_PREV_CHK: begin
				mem_ctl.we = rdata.free;
				waddr = idx_q - IW'(1);
				wdata.offset = rdata.offset;
				wdata.size = rdata.size + SIZE_W'(HEADER_BYTES) + cur_q.size;
				wdata.free = 1'b1;
			end
			S_FREE_WR: mem_ctl.we = 1'b1;
			S_RM_RD: begin
				mem_ctl.re = 1'b1;
				raddr = k_q + IW'(1);
			end
			S_RM_WR: begin
				mem_ctl.we = 1'b1;
				waddr = k_q;
				wdata = rdata;
			end
			default: mem_ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ret_q <= S_DONE;
			count_q <= CW'(1);
			base_q <= '0;
			bytes_q <= BYTES_W'(HEAP_MAX_BYTES);
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_fire && cfg_index == REG_HEAP_BASE) begin
				base_q <= cfg_data;
			end
			if (cfg_fire && cfg_index == REG_HEAP_BYTES) begin
				bytes_q <= bytes_in;
			end
			case (state_q)
				S_INIT: count_q <= CW'(1);
				S_SPLIT_WR: count_q <= count_q + CW'(1);
				S_NEXT_CHK: ret_q <= S_PREV_RD;
				S_PREV_CHK: ret_q <= S_DONE;
				S_RM_RD: begin
					if (!(CW'(k_q) + CW'(1) < count_q)) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: ret_q <= ret_q;
			endcase
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= cmd_beat.command;
				need_q <= need_in;
				ptr_q <= cmd_beat.ptr;
				idx_q <= '0;
				addr_q <= '0;
				status_q <= STAT_NULL;
			end
			S_SCAN_CHK: begin
				if (cmd_q == CMD_ALLOC) begin
					if (fit) begin
						status_q <= STAT_OK;
						addr_q <= seg_addr;
						cur_q.offset <= rdata.offset;
						cur_q.size <= split_ok ? need_q[SIZE_W-1:0] : rdata.size;
						cur_q.free <= 1'b0;
						new_q.offset <= rdata.offset + SIZE_W'(HEADER_BYTES)
							+ need_q[SIZE_W-1:0];
						new_q.size <= rdata.size - need_q[SIZE_W-1:0]
							- SIZE_W'(HEADER_BYTES);
						new_q.free <= 1'b1;
						k_q <= count_q[IW-1:0];
					end else begin
						status_q <= STAT_OOM;
						idx_q <= idx_q + IW'(1);
					end
				end else begin
					if (hit && !rdata.free) begin
						status_q <= STAT_OK;
						cur_q.offset <= rdata.offset;
						cur_q.size <= rdata.size;
						cur_q.free <= 1'b1;
					end else begin
						status_q <= STAT_BAD;
						if (!hit) begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
			end
			S_INS_WR: k_q <= k_q - IW'(1);
			S_NEXT_CHK: begin
				if (rdata.free) begin
					cur_q.size <= cur_q.size + SIZE_W'(HEADER_BYTES) + rdata.size;
					k_q <= idx_q + IW'(1);
				end
			end
			S_PREV_CHK: k_q <= idx_q;
			S_RM_WR: k_q <= k_q + IW'(1);
			default: k_q <= k_q;
		endcase
		if (res_load) begin
			res_q.status <= status_q;
			res_q.addr <= addr_q;
		end
	end

`include "assert_macros.svh"

	`FFHA_ASSERT_ALWAYS(a_count_range, (count_q != '0) && (count_q <= CW'(MAX_SEGMENTS)))
	`FFHA_ASSERT_NEXT(a_cmd_leaves_idle, cmd_fire, state_q != S_IDLE)
	`FFHA_ASSERT_NEXT(a_bytes_rebuild, cfg_fire && cfg_index == REG_HEAP_BYTES, state_q == S_INIT)
	`FFHA_ASSERT_IMPL(a_done_only_once, res_load, state_d == S_IDLE)

endmodule
